// File: hdl/quoted_field_splitter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quoted field splitter.
// Each use checks a property on the rising edge of clock, gated off in reset.
// ----------------------------------------------------------------------------
`ifndef QUOTED_FIELD_SPLITTER_CORE_MACROS_SVH
`define QUOTED_FIELD_SPLITTER_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define QFS_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qfs: same-cycle check failed");
// Next-cycle implication.
`define QFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qfs: next-cycle check failed");
`else
`define QFS_ASSERT_IMPLIES(label, ante, cons)
`define QFS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hdl/qfs_pkg.sv
// ----------------------------------------------------------------------------
// qfs_pkg
// Shared types, codes and constants of the quoted field splitter.
// ----------------------------------------------------------------------------
package qfs_pkg;

   // Field widths.
   localparam int CHAR_W        = 8;
   localparam int KIND_W        = 2;
   localparam int FIELD_INDEX_W = 6;
   localparam int FIELD_COUNT_W = 7;
   localparam int RSP_DATA_W    = 24;

   // Configuration register widths and indexes.
   localparam int SEP_BYTES_W  = 32;
   localparam int SEP_COUNT_W  = 3;
   localparam int MAX_FIELDS_W = 7;
   localparam int SEP_LANES    = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEP_BYTES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEP_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FIELDS = 2'd2;

   localparam logic [SEP_BYTES_W-1:0]  RST_SEP_BYTES  = 32'd32;
   localparam logic [SEP_COUNT_W-1:0]  RST_SEP_COUNT  = 3'd1;
   localparam logic [MAX_FIELDS_W-1:0] RST_MAX_FIELDS = 7'd64;

   // Parameter defaults.
   localparam int DEF_MAX_FIELD_LIMIT = 64;
   localparam int DEF_SEPARATOR_SLOTS = 4;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_DATA       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIELD_END  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STRING_END = 2'd2;

   // Special bytes.
   localparam logic [CHAR_W-1:0] QUOTE_BYTE = 8'h27;
   localparam logic [CHAR_W-1:0] NUL_BYTE   = 8'h00;

   // Result queue geometry (a power of two, at least two).
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One result item, kind in the lowest bits.
   typedef struct packed {
      logic                     last;
      logic [FIELD_COUNT_W-1:0] field_count;
      logic [FIELD_INDEX_W-1:0] field_index;
      logic [CHAR_W-1:0]        out_byte;
      logic [KIND_W-1:0]        kind;
   } qfs_rsp_type;

   // Up to two results written into the queue in one cycle.
   typedef struct packed {
      logic [1:0]  n;
      qfs_rsp_type a;
      qfs_rsp_type b;
   } qfs_push_type;

   function automatic qfs_rsp_type mk_rsp(
      input logic [KIND_W-1:0]        kind_v,
      input logic [CHAR_W-1:0]        data_v,
      input logic [FIELD_INDEX_W-1:0] index_v,
      input logic [FIELD_COUNT_W-1:0] count_v
   );
      qfs_rsp_type r;
      r.last        = 1'b0;
      r.field_count = count_v;
      r.field_index = index_v;
      r.out_byte    = data_v;
      r.kind        = kind_v;
      return r;
   endfunction

endpackage

// File: hdl/quoted_field_splitter_core.sv
// ----------------------------------------------------------------------------
// quoted_field_splitter_core
// Splits a zero-terminated byte stream into fields at configured separators.
// ----------------------------------------------------------------------------
// Usage:
//   String bytes arrive on the req_ channel, one byte per request, a zero
//   byte closing each string. Results leave on the rsp_ channel: data bytes
//   with their field index, field ends with the separator that closed them,
//   and a string end with the field count. rsp_tlast marks the final result
//   that a request produced; a request may produce none, one or two.
//   The csr_ port writes the separator bytes, the number of separator lanes
//   in use and the field limit; write it only while the block is idle.
//   Flow: a request is registered at acceptance, then processed once the
//   queue has room, which writes its results into the queue; the first
//   result is offered from that edge on.
//   Throughput: one request per cycle while the queue has room; the output
//   side gives one result per cycle while rsp_tready is high, so a request
//   that yields both a field end and a string end leaves an extra result
//   for the output side; the four-entry result queue absorbs it.
//   Reset restores the register defaults (space separator, one lane, 64
//   fields) and clears the parser state; the queue starts empty.
//   When rsp_tready is held low, results wait in the queue, and req_tready
//   falls once a request is held and the queue cannot take two more results.
// ----------------------------------------------------------------------------
`include "quoted_field_splitter_core_macros.svh"

module quoted_field_splitter_core
   import qfs_pkg::*;
#(
   parameter int MAX_FIELD_LIMIT = DEF_MAX_FIELD_LIMIT,
   parameter int SEPARATOR_SLOTS = DEF_SEPARATOR_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [CHAR_W-1:0]      req_tdata,   // [7:0] char_in
   // Response channel.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [1:0] kind, [9:2] out_byte,
                                               // [15:10] field_index,
                                               // [22:16] field_count, [23] zero
   output logic                   rsp_tlast,   // last
   // Configuration write port.
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW    = $clog2(MAX_FIELD_LIMIT + 1);
   localparam int LANES = (SEPARATOR_SLOTS < SEP_LANES) ? SEPARATOR_SLOTS : SEP_LANES;

   // Parser phases.
   localparam logic [1:0] PH_SKIP  = 2'd0;
   localparam logic [1:0] PH_FIELD = 2'd1;
   localparam logic [1:0] PH_QUOTE = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   logic [SEP_BYTES_W-1:0]  sep_bytes_ff;
   logic [SEP_COUNT_W-1:0]  sep_count_ff;
   logic [MAX_FIELDS_W-1:0] max_fields_ff;

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic [1:0]        phase_ff, phase_in;
   logic [CW-1:0]     cf_ff, cf_in;
   logic              fhb_ff, fhb_in;

   logic              fire;
   logic              room;
   logic              pop;
   logic              q_not_empty;
   qfs_rsp_type       q_head;
   qfs_push_type      push;
   logic              is_sep;
   logic [CW-1:0]     limit;
   logic [CW-1:0]     cf_inc;
   logic [CW-1:0]     done_cnt;
   logic [CHAR_W-1:0] c;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sep_bytes_ff  <= RST_SEP_BYTES;
         sep_count_ff  <= RST_SEP_COUNT;
         max_fields_ff <= RST_MAX_FIELDS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SEP_BYTES:  sep_bytes_ff  <= csr_wdata[SEP_BYTES_W-1:0];
            CSR_SEP_COUNT:  sep_count_ff  <= csr_wdata[SEP_COUNT_W-1:0];
            CSR_MAX_FIELDS: max_fields_ff <= csr_wdata[MAX_FIELDS_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register: refilled whenever the held byte moves on.
   assign fire        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
      end
   end

   assign c = in_char_ff;

   // Separator match over the lanes in use; a zero lane never matches.
   always_comb begin
      is_sep = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         if ((i < int'(sep_count_ff)) && (sep_bytes_ff[8*i +: 8] != NUL_BYTE)
             && (sep_bytes_ff[8*i +: 8] == c)) begin
            is_sep = 1'b1;
         end
      end
   end

   // Field limit: zero acts as one, large values saturate.
   always_comb begin
      if (max_fields_ff == '0) begin
         limit = CW'(1);
      end else if (int'(max_fields_ff) > MAX_FIELD_LIMIT) begin
         limit = CW'(MAX_FIELD_LIMIT);
      end else begin
         limit = CW'(max_fields_ff);
      end
   end

   assign cf_inc   = CW'(cf_ff + 1'b1);
   // After the limit, an empty closing field is taken back out of the count.
   assign done_cnt = (!fhb_ff && (cf_ff != '0)) ? CW'(cf_ff - 1'b1) : cf_ff;

   // Parser step for the held byte.
   always_comb begin
      phase_in = phase_ff;
      cf_in    = cf_ff;
      fhb_in   = fhb_ff;
      push.n   = 2'd0;
      push.a   = mk_rsp(KIND_DATA, c, FIELD_INDEX_W'(cf_ff), '0);
      push.b   = mk_rsp(KIND_STRING_END, NUL_BYTE, '0,
                        FIELD_COUNT_W'(cf_ff) + FIELD_COUNT_W'(fhb_ff));
      if (fire) begin
         unique case (phase_ff)
            PH_SKIP: begin
               if (c == NUL_BYTE) begin
                  push.n   = 2'd1;
                  push.a   = mk_rsp(KIND_STRING_END, NUL_BYTE, '0,
                                    FIELD_COUNT_W'(cf_ff));
                  phase_in = PH_SKIP;
                  cf_in    = '0;
                  fhb_in   = 1'b0;
               end else if (is_sep) begin
                  phase_in = PH_SKIP;
               end else if (c == QUOTE_BYTE) begin
                  phase_in = PH_QUOTE;
                  fhb_in   = 1'b0;
               end else begin
                  push.n   = 2'd1;
                  phase_in = PH_FIELD;
                  fhb_in   = 1'b1;
               end
            end
            PH_FIELD, PH_QUOTE: begin
               if (c == NUL_BYTE) begin
                  // Close the open field, then end the string.
                  push.n   = 2'd2;
                  push.a   = mk_rsp(KIND_FIELD_END, NUL_BYTE, FIELD_INDEX_W'(cf_ff), '0);
                  phase_in = PH_SKIP;
                  cf_in    = '0;
                  fhb_in   = 1'b0;
               end else if (phase_ff == PH_QUOTE) begin
                  if (c == QUOTE_BYTE) begin
                     phase_in = PH_FIELD;
                  end else begin
                     push.n = 2'd1;
                     fhb_in = 1'b1;
                  end
               end else if (is_sep) begin
                  push.n = 2'd1;
                  push.a = mk_rsp(KIND_FIELD_END, c, FIELD_INDEX_W'(cf_ff), '0);
                  cf_in  = cf_inc;
                  if (cf_inc >= limit) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_SKIP;
                     fhb_in   = 1'b0;
                  end
               end else if (c == QUOTE_BYTE) begin
                  phase_in = PH_QUOTE;
               end else begin
                  push.n = 2'd1;
                  fhb_in = 1'b1;
               end
            end
            PH_DONE: begin
               if (c == NUL_BYTE) begin
                  push.n   = 2'd1;
                  push.a   = mk_rsp(KIND_STRING_END, NUL_BYTE, '0,
                                    FIELD_COUNT_W'(done_cnt));
                  phase_in = PH_SKIP;
                  cf_in    = '0;
                  fhb_in   = 1'b0;
               end
            end
         endcase
      end
      // Mark the final result of this byte.
      if (push.n == 2'd1) begin
         push.a.last = 1'b1;
      end
      if (push.n == 2'd2) begin
         push.b.last = 1'b1;
      end
   end

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         cf_ff    <= '0;
         fhb_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cf_ff    <= cf_in;
         fhb_ff   <= fhb_in;
      end
   end

   // Result queue and response channel.
   assign pop = rsp_tvalid && rsp_tready;

   qfs_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .room      (room),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   assign rsp_tvalid = q_not_empty;
   assign rsp_tdata  = {1'b0, q_head.field_count, q_head.field_index,
                        q_head.out_byte, q_head.kind};
   assign rsp_tlast  = q_head.last;

   `QFS_ASSERT_NEXT(a_restart, fire && (c == NUL_BYTE), (phase_ff == PH_SKIP) && (cf_ff == '0) && !fhb_ff)
   `QFS_ASSERT_IMPLIES(a_done_has_fields, phase_ff == PH_DONE, cf_ff != '0)
   `QFS_ASSERT_IMPLIES(a_pair_is_end, push.n == 2'd2, (push.a.kind == KIND_FIELD_END) && (push.b.kind == KIND_STRING_END))

endmodule

// File: hdl/qfs_rsp_queue.sv
// ----------------------------------------------------------------------------
// qfs_rsp_queue
// Small result queue: takes up to two results a cycle, gives one a cycle when popped.
// ----------------------------------------------------------------------------
`include "quoted_field_splitter_core_macros.svh"

module qfs_rsp_queue
   import qfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  qfs_push_type push,
   input  logic         pop,
   output logic         room,
   output logic         not_empty,
   output qfs_rsp_type  head
);

   qfs_rsp_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QPTR_W-1:0] wr_next;

   // Pointer arithmetic wraps naturally since the depth is a power of two.
   assign wr_next   = QPTR_W'(wr_ff + 1'b1);
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ff];

   // Space for a worst-case pair of results, counting the entry leaving now.
   assign room = (int'(count_ff) + 2) <= (QUEUE_DEPTH + int'(pop));

   always_comb begin
      wr_in    = QPTR_W'(wr_ff + QPTR_W'(push.n));
      rd_in    = pop ? QPTR_W'(rd_ff + 1'b1) : rd_ff;
      count_in = QCNT_W'(count_ff + QCNT_W'(push.n) - QCNT_W'(pop));
   end

   // Storage writes, one or two entries at the tail.
   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         mem_ff[wr_ff] <= push.a;
      end
      if (push.n == 2'd2) begin
         mem_ff[wr_next] <= push.b;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `QFS_ASSERT_IMPLIES(a_no_overflow, push.n != 2'd0, (int'(count_ff) + int'(push.n) - int'(pop)) <= QUEUE_DEPTH)
   `QFS_ASSERT_IMPLIES(a_no_underflow, pop, count_ff != '0)

endmodule
